### rtl/core/crctf_pkg.sv
// Shared constants for the CRC-16 telemetry framer.
`timescale 1ns / 1ps
`default_nettype none
package crctf_pkg;

  // Payload bytes per frame, 1..8
  localparam int unsigned PAYLOAD_BYTES = 8;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CRC_W   = 16;
  localparam int unsigned COUNT_W = 3;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

  // Pending CRC bytes after the last payload beat
  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_HI   = 2'd1,
    PEND_BOTH = 2'd2
  } pend_t;

endpackage
`default_nettype wire

### rtl/core/crctf_fold.sv
// Folds one byte into a reflected CRC-16/Modbus value, eight bit steps unrolled.
`timescale 1ns / 1ps
`default_nettype none
module crctf_fold (
  input  wire logic [crctf_pkg::CRC_W-1:0]  crc_in,
  input  wire logic [crctf_pkg::BYTE_W-1:0] data_in,
  output logic      [crctf_pkg::CRC_W-1:0]  crc_out
);

  always_comb begin
    logic [crctf_pkg::CRC_W-1:0] c;
    c = crc_in ^ {{(crctf_pkg::CRC_W - crctf_pkg::BYTE_W){1'b0}}, data_in};
    for (int k = 0; k < crctf_pkg::BYTE_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ crctf_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule
`default_nettype wire

### rtl/core/crc16_telemetry_framer.sv
// An accepted payload beat passes from the input skid register into the output register; a beat
// that follows the last byte of a frame also waits behind the two CRC beats, and output stalls hold it.
// One payload byte per cycle while the output is not stalled and no CRC beats are owed; each frame
// adds two CRC beats, which share the single output register with the payload beats.
// A one-beat input skid register takes one more beat while the output is stalled.
// Reset (synchronous, rst_n low): all beats dropped, CRC back to 0xFFFF, byte count to zero.
`timescale 1ns / 1ps
`default_nettype none
module crc16_telemetry_framer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] payload_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] tx_byte
  output logic             out_tuser,  // [0] is_check_byte
  output logic             out_tlast   // frame_end
);

  localparam int unsigned TAKEN_W = crctf_pkg::COUNT_W + 1;

  logic                              hold_valid_r, hold_valid_nxt;
  logic [crctf_pkg::BYTE_W-1:0]      hold_byte_r;
  logic [crctf_pkg::CRC_W-1:0]       crc_acc_r, crc_acc_nxt;
  logic [crctf_pkg::CRC_W-1:0]       crc_hold_r, crc_hold_nxt;
  logic [crctf_pkg::COUNT_W-1:0]     count_r, count_nxt;
  crctf_pkg::pend_t                  pend_r, pend_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic [crctf_pkg::BYTE_W-1:0]      out_byte_r, out_byte_nxt;
  logic                              out_user_r, out_user_nxt;
  logic                              out_last_r, out_last_nxt;

  logic [crctf_pkg::CRC_W-1:0]       crc_fold;
  logic [TAKEN_W-1:0]                taken;
  logic                              last_byte;
  logic                              out_free;
  logic                              advance;
  logic                              in_fire;

  crctf_fold u_fold (
    .crc_in  (crc_acc_r),
    .data_in (hold_byte_r),
    .crc_out (crc_fold)
  );

  assign taken     = {1'b0, count_r} + TAKEN_W'(1);
  assign last_byte = (taken >= TAKEN_W'(crctf_pkg::PAYLOAD_BYTES)) || taken[TAKEN_W-1];
  assign out_free  = !out_valid_r || out_tready;
  // CRC beats take the output slot before the next payload beat
  assign advance   = hold_valid_r && (pend_r == crctf_pkg::PEND_NONE) && out_free;
  assign in_tready = !hold_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    crc_acc_nxt    = crc_acc_r;
    crc_hold_nxt   = crc_hold_r;
    count_nxt      = count_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r;
    out_byte_nxt   = out_byte_r;
    out_user_nxt   = out_user_r;
    out_last_nxt   = out_last_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_fire) begin
      hold_valid_nxt = 1'b1;
    end else if (advance) begin
      hold_valid_nxt = 1'b0;
    end

    if (out_free) begin
      unique case (pend_r)
        crctf_pkg::PEND_BOTH: begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = crc_hold_r[7:0];
          out_user_nxt  = 1'b1;
          out_last_nxt  = 1'b0;
          pend_nxt      = crctf_pkg::PEND_HI;
        end
        crctf_pkg::PEND_HI: begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = crc_hold_r[15:8];
          out_user_nxt  = 1'b1;
          out_last_nxt  = 1'b1;
          pend_nxt      = crctf_pkg::PEND_NONE;
        end
        default: begin
          if (hold_valid_r) begin
            out_valid_nxt = 1'b1;
            out_byte_nxt  = hold_byte_r;
            out_user_nxt  = 1'b0;
            out_last_nxt  = 1'b0;
            if (last_byte) begin
              crc_hold_nxt = crc_fold;
              crc_acc_nxt  = crctf_pkg::CRC_INIT;
              count_nxt    = '0;
              pend_nxt     = crctf_pkg::PEND_BOTH;
            end else begin
              crc_acc_nxt  = crc_fold;
              count_nxt    = taken[crctf_pkg::COUNT_W-1:0];
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      crc_acc_r    <= crctf_pkg::CRC_INIT;
      count_r      <= '0;
      pend_r       <= crctf_pkg::PEND_NONE;
      out_valid_r  <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      crc_acc_r    <= crc_acc_nxt;
      count_r      <= count_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hold_byte_r <= in_tdata;
    end
    crc_hold_r <= crc_hold_nxt;
    out_byte_r <= out_byte_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  // Last payload beat of a frame sits in the output register
  a_pend_both: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == crctf_pkg::PEND_BOTH |-> out_valid_r && !out_user_r && !out_last_r)
    else $error("pending CRC without the last payload beat in the output");

  // CRC low byte is showing while the high byte waits
  a_pend_hi: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == crctf_pkg::PEND_HI |-> out_valid_r && out_user_r && !out_last_r)
    else $error("CRC low byte not in the output while the high byte is pending");

  // Frame state is already back at reset while the CRC beats drain
  a_pend_reset: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != crctf_pkg::PEND_NONE |-> crc_acc_r == crctf_pkg::CRC_INIT && count_r == '0)
    else $error("CRC or byte count not cleared at frame end");

  // Frame end only on a check byte
  a_last_check: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_user_r)
    else $error("frame end on a payload beat");

  // No payload beat leaves the skid register while CRC beats are owed
  a_no_advance: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != crctf_pkg::PEND_NONE && hold_valid_r && !in_tready |=> hold_valid_r)
    else $error("held payload beat lost during CRC beats");

endmodule
`default_nettype wire
